### rtl/iram_pkg.sv
package iram_pkg;

    localparam int unsigned PHASE_W = 10;
    localparam int unsigned ADDR_W  = 7;
    localparam int unsigned BYTE_W  = 8;

    localparam logic [PHASE_W-1:0] PHASE_TICKS_RST    = 10'd100;
    localparam logic [ADDR_W-1:0]  DEVICE_ADDRESS_RST = 7'd104;

    // configuration register indexes
    localparam logic CFG_PHASE_TICKS    = 1'b0;
    localparam logic CFG_DEVICE_ADDRESS = 1'b1;

    // one bus tick as seen by the sequencer
    typedef struct packed {
        logic              go;
        logic              mode;
        logic [BYTE_W-1:0] reg_addr;
        logic [BYTE_W-1:0] write_data;
        logic              sda_in;
    } tick_t;

    // line levels and status for one tick
    typedef struct packed {
        logic              scl;
        logic              sda_drive;
        logic              busy;
        logic              done;
        logic [BYTE_W-1:0] read_data;
    } res_t;

endpackage

### rtl/iram_seq.sv
module iram_seq (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             step_en,
    input  iram_pkg::tick_t                  tick,
    input  logic [iram_pkg::PHASE_W-1:0]     phase_ticks,
    input  logic [iram_pkg::ADDR_W-1:0]      device_address,
    output iram_pkg::res_t                   res
);
    import iram_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_START  = 4'd1;
    localparam logic [3:0] ST_ADDRW  = 4'd2;
    localparam logic [3:0] ST_ACKA   = 4'd3;
    localparam logic [3:0] ST_REG    = 4'd4;
    localparam logic [3:0] ST_ACKR   = 4'd5;
    localparam logic [3:0] ST_WDATA  = 4'd6;
    localparam logic [3:0] ST_ACKD   = 4'd7;
    localparam logic [3:0] ST_STOP   = 4'd8;
    localparam logic [3:0] ST_GAP    = 4'd9;
    localparam logic [3:0] ST_RSTART = 4'd10;
    localparam logic [3:0] ST_ADDRR  = 4'd11;
    localparam logic [3:0] ST_ACKAR  = 4'd12;
    localparam logic [3:0] ST_RBYTE  = 4'd13;
    localparam logic [3:0] ST_NACK   = 4'd14;

    // number of sub-phases in each step
    function automatic logic [4:0] sub_count(input logic [3:0] s);
        case (s)
            ST_START, ST_RSTART:                          sub_count = 5'd2;
            ST_ADDRW, ST_REG, ST_WDATA, ST_ADDRR, ST_RBYTE: sub_count = 5'd16;
            ST_ACKA, ST_ACKR, ST_ACKD, ST_ACKAR, ST_NACK:   sub_count = 5'd3;
            ST_STOP:                                      sub_count = 5'd4;
            ST_GAP:                                       sub_count = 5'd10;
            default:                                      sub_count = 5'd1;
        endcase
    endfunction

    logic [3:0]         step_reg, step_next;
    logic [3:0]         bit_reg, bit_next;
    logic [PHASE_W-1:0] count_reg, count_next;
    logic [BYTE_W-1:0]  shift_reg, shift_next;
    logic [BYTE_W-1:0]  capt_reg, capt_next;
    logic               mode_reg, mode_next;
    logic [BYTE_W-1:0]  regad_reg, regad_next;
    logic [BYTE_W-1:0]  data_reg, data_next;

    logic [3:0]         s;
    logic [3:0]         b;
    logic [3:0]         b_inc;
    logic [PHASE_W-1:0] pt;
    logic [PHASE_W:0]   count_inc;
    logic               is_ack;
    logic               hold;
    logic               scl_lvl;
    logic               sda_lvl;
    logic               busy;
    logic               done;

    assign pt = (phase_ticks == '0) ? PHASE_W'(1) : phase_ticks;

    always_comb
    begin
        mode_next  = mode_reg;
        regad_next = regad_reg;
        data_next  = data_reg;
        shift_next = shift_reg;
        capt_next  = capt_reg;
        s          = step_reg;
        b          = bit_reg;
        count_next = count_reg;
        done       = 1'b0;
        hold       = 1'b0;

        // undefined step codes behave as idle
        if (step_reg == ST_IDLE || step_reg > ST_NACK)
        begin
            s = ST_IDLE;
            if (tick.go)
            begin
                mode_next  = tick.mode;
                regad_next = tick.reg_addr;
                data_next  = tick.write_data;
                s          = ST_START;
                b          = 4'd0;
                count_next = '0;
            end
        end

        scl_lvl = 1'b1;
        sda_lvl = 1'b1;
        case (s)
            ST_START, ST_RSTART:
                sda_lvl = (b == 4'd0);
            ST_ADDRW, ST_REG, ST_WDATA, ST_ADDRR:
            begin
                scl_lvl = b[0];
                sda_lvl = shift_reg[3'd7 - b[3:1]];
            end
            ST_RBYTE:
                scl_lvl = b[0];
            ST_ACKA, ST_ACKR, ST_ACKD, ST_ACKAR:
                scl_lvl = (b == 4'd1);
            ST_NACK:
                scl_lvl = (b == 4'd2);
            ST_STOP:
            begin
                scl_lvl = (b >= 4'd2);
                sda_lvl = (b == 4'd0) || (b == 4'd3);
            end
            default:
                ;
        endcase

        busy      = (s != ST_IDLE);
        is_ack    = (s == ST_ACKA) || (s == ST_ACKR) || (s == ST_ACKD) || (s == ST_ACKAR);
        count_inc = {1'b0, count_next} + (PHASE_W+1)'(1);
        b_inc     = b + 4'd1;
        step_next = s;
        bit_next  = b;

        if (busy)
        begin
            if (count_inc >= {1'b0, pt})
            begin
                // ack high phase waits for the slave to pull sda low
                hold = is_ack && (b == 4'd1) && tick.sda_in;
                if (!hold)
                begin
                    if (s == ST_RBYTE && b[0])
                        shift_next = {shift_reg[BYTE_W-2:0], tick.sda_in};
                    count_next = '0;
                    bit_next   = b_inc;
                    if (b_inc == 4'd0 || {1'b0, b_inc} >= sub_count(s))
                    begin
                        bit_next = 4'd0;
                        case (s)
                            ST_START:  step_next = ST_ADDRW;
                            ST_ADDRW:  step_next = ST_ACKA;
                            ST_ACKA:   step_next = ST_REG;
                            ST_REG:    step_next = ST_ACKR;
                            ST_ACKR:   step_next = mode_next ? ST_RSTART : ST_WDATA;
                            ST_WDATA:  step_next = ST_ACKD;
                            ST_ACKD:   step_next = ST_STOP;
                            ST_STOP:
                            begin
                                step_next = mode_next ? ST_IDLE : ST_GAP;
                                done      = mode_next;
                            end
                            ST_GAP:
                            begin
                                step_next = ST_IDLE;
                                done      = 1'b1;
                            end
                            ST_RSTART: step_next = ST_ADDRR;
                            ST_ADDRR:  step_next = ST_ACKAR;
                            ST_ACKAR:  step_next = ST_RBYTE;
                            ST_RBYTE:
                            begin
                                capt_next = shift_next;
                                step_next = ST_NACK;
                            end
                            ST_NACK:   step_next = ST_STOP;
                            default:   step_next = ST_IDLE;
                        endcase
                        // load the byte for the step just entered
                        case (step_next)
                            ST_ADDRW: shift_next = {device_address, 1'b0};
                            ST_ADDRR: shift_next = {device_address, 1'b1};
                            ST_REG:   shift_next = regad_next;
                            ST_WDATA: shift_next = data_next;
                            ST_RBYTE: shift_next = '0;
                            default:  ;
                        endcase
                    end
                end
            end
            else
            begin
                count_next = count_inc[PHASE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= ST_IDLE;
            bit_reg   <= '0;
            count_reg <= '0;
            shift_reg <= '0;
            capt_reg  <= '0;
            mode_reg  <= 1'b0;
            regad_reg <= '0;
            data_reg  <= '0;
        end
        else if (step_en)
        begin
            step_reg  <= step_next;
            bit_reg   <= bit_next;
            count_reg <= count_next;
            shift_reg <= shift_next;
            capt_reg  <= capt_next;
            mode_reg  <= mode_next;
            regad_reg <= regad_next;
            data_reg  <= data_next;
        end
    end

    assign res.scl       = scl_lvl;
    assign res.sda_drive = sda_lvl;
    assign res.busy      = busy;
    assign res.done      = done;
    assign res.read_data = capt_next;

endmodule

### rtl/i2c_register_access_master_top.sv
// Tick-driven I2C master for single-register writes and reads. Each input word is one
// bus tick and yields one output word carrying the SCL/SDA levels for that tick, busy,
// a done pulse and the last byte read. One word is taken every clock cycle unless both
// the input register and the output register hold a word and out_ready is low. A word goes
// from the input register through the sequencer update into the output register. Each bus
// phase lasts phase_ticks ticks (0 counts as 1); an ack phase waits with no timeout until
// the slave pulls SDA low. Write configuration only while no word is in flight.
module i2c_register_access_master_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          go,
    input  logic                          mode,
    input  logic [iram_pkg::BYTE_W-1:0]   reg_addr,
    input  logic [iram_pkg::BYTE_W-1:0]   write_data,
    input  logic                          sda_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          scl,
    output logic                          sda_drive,
    output logic                          busy_res,
    output logic                          done_res,
    output logic [iram_pkg::BYTE_W-1:0]   read_data,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [iram_pkg::PHASE_W-1:0]  cfg_data
);
    import iram_pkg::*;

    logic [PHASE_W-1:0] phase_ticks_reg;
    logic [ADDR_W-1:0]  dev_addr_reg;
    logic               s1_valid_reg;
    tick_t              s1_tick_reg;
    logic               out_valid_reg;
    res_t               out_reg;
    res_t               res;
    tick_t              in_tick;
    logic               advance;

    assign in_tick.go         = go;
    assign in_tick.mode       = mode;
    assign in_tick.reg_addr   = reg_addr;
    assign in_tick.write_data = write_data;
    assign in_tick.sda_in     = sda_in;

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= PHASE_TICKS_RST;
            dev_addr_reg    <= DEVICE_ADDRESS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PHASE_TICKS:    phase_ticks_reg <= cfg_data;
                CFG_DEVICE_ADDRESS: dev_addr_reg    <= cfg_data[ADDR_W-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_tick_reg <= in_tick;
        if (advance)
            out_reg <= res;
    end

    iram_seq u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .step_en        (advance),
        .tick           (s1_tick_reg),
        .phase_ticks    (phase_ticks_reg),
        .device_address (dev_addr_reg),
        .res            (res)
    );

    assign out_valid = out_valid_reg;
    assign scl       = out_reg.scl;
    assign sda_drive = out_reg.sda_drive;
    assign busy_res  = out_reg.busy;
    assign done_res  = out_reg.done;
    assign read_data = out_reg.read_data;

endmodule

### test/iram_bus_checker.sv
module iram_bus_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic                         go,
    input  logic                         mode,
    input  logic [iram_pkg::BYTE_W-1:0]  reg_addr,
    input  logic [iram_pkg::BYTE_W-1:0]  write_data,
    input  logic                         sda_in,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic                         scl,
    input  logic                         sda_drive,
    input  logic                         busy_res,
    input  logic                         done_res,
    input  logic [iram_pkg::BYTE_W-1:0]  read_data,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [iram_pkg::PHASE_W-1:0] cfg_data,
    output int                           failures,
    output int                           pending,
    output logic                         bus_idle,
    output int                           tick_count,
    output int                           transfer_count,
    output int                           read_count
);
    import iram_pkg::*;

    localparam int  REPORT_MAX = 10;
    localparam logic RW_WRITE  = 1'b0;
    localparam logic RW_READ   = 1'b1;

    typedef enum logic [4:0] {
        SEQ_IDLE   = 5'd0,
        SEQ_START  = 5'd1,
        SEQ_ADDR_W = 5'd2,
        SEQ_ACK_A  = 5'd3,
        SEQ_REG    = 5'd4,
        SEQ_ACK_R  = 5'd5,
        SEQ_WDATA  = 5'd6,
        SEQ_ACK_D  = 5'd7,
        SEQ_STOP   = 5'd8,
        SEQ_GAP    = 5'd9,
        SEQ_RSTART = 5'd10,
        SEQ_ADDR_R = 5'd11,
        SEQ_ACK_AR = 5'd12,
        SEQ_RBYTE  = 5'd13,
        SEQ_NACK   = 5'd14
    } seq_e;

    seq_e               seq;
    logic [3:0]         bit_pos;
    logic [PHASE_W-1:0] tick_pos;
    logic [BYTE_W-1:0]  shifter;
    logic [BYTE_W-1:0]  captured;
    logic [BYTE_W-1:0]  req_reg;
    logic [BYTE_W-1:0]  req_data;
    logic               req_read;
    logic               scl_lvl;
    logic               sda_lvl;
    logic [PHASE_W-1:0] phase_len;
    logic [ADDR_W-1:0]  dev_addr;

    res_t levels_due[$];
    int   fail_n;
    int   mismatch_n;
    int   tick_n;
    int   xfer_n;
    int   rd_n;

    function automatic int unsigned phases_in(seq_e s);
        case (s)
            SEQ_START, SEQ_RSTART: return 2;
            SEQ_ADDR_W, SEQ_REG, SEQ_WDATA, SEQ_ADDR_R, SEQ_RBYTE: return 16;
            SEQ_ACK_A, SEQ_ACK_R, SEQ_ACK_D, SEQ_ACK_AR, SEQ_NACK: return 3;
            SEQ_STOP: return 4;
            SEQ_GAP: return 10;
            default: return 1;
        endcase
    endfunction

    function automatic logic is_ack_step(seq_e s);
        case (s)
            SEQ_ACK_A, SEQ_ACK_R, SEQ_ACK_D, SEQ_ACK_AR: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void clear_model();
        phase_len = PHASE_TICKS_RST;
        dev_addr  = DEVICE_ADDRESS_RST;
        seq       = SEQ_IDLE;
        bit_pos   = '0;
        tick_pos  = '0;
        shifter   = '0;
        captured  = '0;
        req_read  = 1'b0;
        req_reg   = '0;
        req_data  = '0;
        scl_lvl   = 1'b1;
        sda_lvl   = 1'b1;
    endfunction

    function automatic void enter_step(seq_e s);
        seq      = s;
        bit_pos  = '0;
        tick_pos = '0;
        case (s)
            SEQ_ADDR_W: shifter = {dev_addr, RW_WRITE};
            SEQ_ADDR_R: shifter = {dev_addr, RW_READ};
            SEQ_REG:    shifter = req_reg;
            SEQ_WDATA:  shifter = req_data;
            SEQ_RBYTE:  shifter = '0;
            default: ;
        endcase
    endfunction

    // returns 1 when the transfer ends with this step
    function automatic logic close_step();
        logic fin;
        fin = 1'b0;
        case (seq)
            SEQ_START:  enter_step(SEQ_ADDR_W);
            SEQ_ADDR_W: enter_step(SEQ_ACK_A);
            SEQ_ACK_A:  enter_step(SEQ_REG);
            SEQ_REG:    enter_step(SEQ_ACK_R);
            SEQ_ACK_R:  enter_step(req_read ? SEQ_RSTART : SEQ_WDATA);
            SEQ_WDATA:  enter_step(SEQ_ACK_D);
            SEQ_ACK_D:  enter_step(SEQ_STOP);
            SEQ_STOP:
            begin
                // reads skip the recovery gap
                if (req_read)
                begin
                    enter_step(SEQ_IDLE);
                    fin = 1'b1;
                end
                else
                    enter_step(SEQ_GAP);
            end
            SEQ_GAP:
            begin
                enter_step(SEQ_IDLE);
                fin = 1'b1;
            end
            SEQ_RSTART: enter_step(SEQ_ADDR_R);
            SEQ_ADDR_R: enter_step(SEQ_ACK_AR);
            SEQ_ACK_AR: enter_step(SEQ_RBYTE);
            SEQ_RBYTE:
            begin
                captured = shifter;
                enter_step(SEQ_NACK);
            end
            SEQ_NACK:   enter_step(SEQ_STOP);
            default:    enter_step(SEQ_IDLE);
        endcase
        return fin;
    endfunction

    function automatic res_t advance_bus(tick_t t);
        res_t               r;
        logic               fin;
        logic               hold;
        logic               c;
        logic               d;
        logic [PHASE_W-1:0] len;
        seq_e               s;
        fin = 1'b0;
        len = (phase_len == '0) ? PHASE_W'(1) : phase_len;
        if (seq == SEQ_IDLE && t.go)
        begin
            req_read = t.mode;
            req_reg  = t.reg_addr;
            req_data = t.write_data;
            enter_step(SEQ_START);
        end

        c = 1'b1;
        d = 1'b1;
        case (seq)
            SEQ_START, SEQ_RSTART: d = (bit_pos == 4'd0);
            SEQ_ADDR_W, SEQ_REG, SEQ_WDATA, SEQ_ADDR_R:
            begin
                c = bit_pos[0];
                d = shifter[3'd7 - bit_pos[3:1]];
            end
            SEQ_RBYTE: c = bit_pos[0];
            SEQ_ACK_A, SEQ_ACK_R, SEQ_ACK_D, SEQ_ACK_AR: c = (bit_pos == 4'd1);
            SEQ_NACK: c = (bit_pos == 4'd2);
            SEQ_STOP:
            begin
                c = (bit_pos >= 4'd2);
                d = (bit_pos == 4'd0 || bit_pos == 4'd3);
            end
            default: ;
        endcase
        scl_lvl = c;
        sda_lvl = d;

        r.busy = (seq != SEQ_IDLE);
        if (r.busy)
        begin
            if ({1'b0, tick_pos} + 1 >= {1'b0, len})
            begin
                s = seq;
                // the ack high phase stretches until the slave pulls sda low
                hold = is_ack_step(s) && bit_pos == 4'd1 && t.sda_in;
                if (!hold)
                begin
                    if (s == SEQ_RBYTE && bit_pos[0])
                        shifter = {shifter[BYTE_W-2:0], t.sda_in};
                    tick_pos = '0;
                    bit_pos  = bit_pos + 4'd1;
                    if (bit_pos == 4'd0 || bit_pos >= phases_in(s))
                        fin = close_step();
                end
            end
            else
                tick_pos = tick_pos + 1'b1;
        end

        r.scl       = scl_lvl;
        r.sda_drive = sda_lvl;
        r.done      = fin;
        r.read_data = captured;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tick_t t;
        res_t  want;
        res_t  got;
        if (!rst_n)
        begin
            clear_model();
            levels_due.delete();
            fail_n     = 0;
            mismatch_n = 0;
            tick_n     = 0;
            xfer_n     = 0;
            rd_n       = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_PHASE_TICKS)
                    phase_len = cfg_data;
                else if (cfg_index == CFG_DEVICE_ADDRESS)
                    dev_addr = cfg_data[ADDR_W-1:0];
            end

            if (in_valid && in_ready)
            begin
                t = {go, mode, reg_addr, write_data, sda_in};
                want = advance_bus(t);
                levels_due.push_back(want);
                tick_n++;
                if (want.done)
                begin
                    xfer_n++;
                    if (req_read)
                        rd_n++;
                end
            end

            if (out_valid && out_ready)
            begin
                got = {scl, sda_drive, busy_res, done_res, read_data};
                if (levels_due.size() == 0)
                begin
                    fail_n++;
                    if (fail_n <= REPORT_MAX)
                        $display("output word with nothing due: scl=%0b sda=%0b busy=%0b done=%0b data=%02h",
                                 got.scl, got.sda_drive, got.busy, got.done, got.read_data);
                end
                else
                begin
                    want = levels_due.pop_front();
                    mismatch_n++;
                    if (got.scl !== want.scl || got.sda_drive !== want.sda_drive ||
                        got.busy !== want.busy || got.done !== want.done ||
                        got.read_data !== want.read_data)
                    begin
                        fail_n++;
                        if (fail_n <= REPORT_MAX)
                        begin
                            $display("word %0d: want scl=%0b sda=%0b busy=%0b done=%0b data=%02h",
                                     mismatch_n, want.scl, want.sda_drive, want.busy,
                                     want.done, want.read_data);
                            $display("word %0d: got  scl=%0b sda=%0b busy=%0b done=%0b data=%02h",
                                     mismatch_n, got.scl, got.sda_drive, got.busy,
                                     got.done, got.read_data);
                        end
                    end
                end
            end
        end

        failures       <= fail_n;
        pending        <= levels_due.size();
        bus_idle       <= (seq == SEQ_IDLE);
        tick_count     <= tick_n;
        transfer_count <= xfer_n;
        read_count     <= rd_n;
    end

endmodule

### test/tb_i2c_register_access_master_top.sv
module tb_i2c_register_access_master_top;
    import iram_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 4;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic               in_ready;
    logic               go         = 1'b0;
    logic               mode       = 1'b0;
    logic [BYTE_W-1:0]  reg_addr   = '0;
    logic [BYTE_W-1:0]  write_data = '0;
    logic               sda_in     = 1'b1;
    logic               out_valid;
    logic               out_ready  = 1'b0;
    logic               scl;
    logic               sda_drive;
    logic               busy_res;
    logic               done_res;
    logic [BYTE_W-1:0]  read_data;
    logic               cfg_we     = 1'b0;
    logic               cfg_index  = CFG_PHASE_TICKS;
    logic [PHASE_W-1:0] cfg_data   = '0;

    int   failures;
    int   pending;
    logic bus_idle;
    int   tick_count;
    int   transfer_count;
    int   read_count;

    logic idling     = 1'b1;
    int   quiet      = 0;
    int   stall_left = 0;
    int   settings_n = 0;

    always #6 clk = ~clk;

    i2c_register_access_master_top dut (.*);

    iram_bus_checker bus_check (.*);

    // receiver stalls in bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (idling && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(0, 14);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("[i2c_register_access_master_top] ERROR");
                $finish;
            end
        end
    end

    task automatic send_tick(logic t_go, logic t_mode, logic [BYTE_W-1:0] t_reg,
                             logic [BYTE_W-1:0] t_data, logic t_sda);
        if (idling && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        go         <= t_go;
        mode       <= t_mode;
        reg_addr   <= t_reg;
        write_data <= t_data;
        sda_in     <= t_sda;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic run_random(int n_ticks, int go_pct, int sda_one_pct);
        repeat (n_ticks)
            send_tick($urandom_range(0, 99) < go_pct, 1'($urandom_range(0, 1)),
                      BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                      $urandom_range(0, 99) < sda_one_pct);
    endtask

    // run the bus down to idle with no new requests, then let every word drain
    task automatic settle_bus(int sda_one_pct);
        do
            send_tick(1'b0, 1'($urandom_range(0, 1)), BYTE_W'($urandom_range(0, 255)),
                      BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 99) < sda_one_pct);
        while (!bus_idle);
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_bus_config(logic [PHASE_W-1:0] ticks, logic [PHASE_W-1:0] addr_word);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PHASE_TICKS;
        cfg_data  <= ticks;
        @(posedge clk);
        cfg_index <= CFG_DEVICE_ADDRESS;
        cfg_data  <= addr_word;
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_n++;
    endtask

    task automatic set_phase_ticks(logic [PHASE_W-1:0] ticks);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PHASE_TICKS;
        cfg_data  <= ticks;
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_n++;
    endtask

    task automatic bus_request(logic t_mode, logic [BYTE_W-1:0] t_reg,
                               logic [BYTE_W-1:0] t_data, int sda_one_pct);
        send_tick(1'b1, t_mode, t_reg, t_data, $urandom_range(0, 99) < sda_one_pct);
        settle_bus(sda_one_pct);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // short phases, device address left at its reset value of 104
        set_phase_ticks(10'd1);
        bus_request(1'b0, 8'hA5, 8'h5A, 40);

        // zero phase length behaves as one tick
        set_bus_config(10'd0, 10'd0);
        bus_request(1'b0, 8'h00, 8'hFF, 30);
        // slave slow to ack, read byte mostly ones
        bus_request(1'b1, 8'hFF, 8'h00, 90);
        // requests arriving mid-transfer must be ignored
        send_tick(1'b1, 1'b0, 8'h3C, 8'hC3, 1'b0);
        run_random(24, 100, 50);
        settle_bus(50);

        set_bus_config(10'd1, 10'd127);
        bus_request(1'b0, 8'hFF, 8'h00, 10);
        bus_request(1'b1, 8'h00, 8'hFF, 10);

        repeat (2)
        begin
            set_bus_config(PHASE_W'($urandom_range(1, 3)), PHASE_W'($urandom_range(0, 1023)));
            run_random(100, 25, $urandom_range(15, 70));
            settle_bus(40);
        end

        idling <= 1'b0;
        set_bus_config(10'd2, PHASE_W'($urandom_range(0, 1023)));
        run_random(200, 25, 40);
        settle_bus(40);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d bus ticks checked across %0d register settings, phase length 0 to 3",
                 tick_count, settings_n);
        $display("%0d transfers completed, %0d of them register reads",
                 transfer_count, read_count);
        if (failures == 0 && pending == 0)
            $display("[i2c_register_access_master_top] OK");
        else
            $display("[i2c_register_access_master_top] ERROR");
        $finish;
    end

endmodule
